[src/ecsf_pkg.sv]
// Package for the ESC/POS command stream filter.
// Holds parser phases, token kinds, control byte codes and argument count tables.
// No dependencies.
package ecsf_pkg;

  // Control and prefix bytes
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteLf    = 8'h0a;
  localparam logic [7:0] ByteFf    = 8'h0c;
  localparam logic [7:0] ByteCr    = 8'h0d;
  localparam logic [7:0] ByteDle   = 8'h10;
  localparam logic [7:0] ByteCan   = 8'h18;
  localparam logic [7:0] ByteEsc   = 8'h1b;
  localparam logic [7:0] ByteFs    = 8'h1c;
  localparam logic [7:0] ByteGs    = 8'h1d;
  localparam logic [7:0] ByteUline = 8'h2d;

  // Selector codes after GS V
  localparam logic [7:0] CutFull0    = 8'd0;
  localparam logic [7:0] CutPart0    = 8'd1;
  localparam logic [7:0] CutFull48   = 8'd48;
  localparam logic [7:0] CutPart49   = 8'd49;
  localparam logic [7:0] CutFeedFull = 8'd65;
  localparam logic [7:0] CutFeedPart = 8'd66;

  // Selector range after ESC c that takes one argument byte
  localparam logic [7:0] EscCSelLo = 8'h33;
  localparam logic [7:0] EscCSelHi = 8'h35;

  typedef enum logic [2:0] {
    PhIdle,
    PhDle,
    PhEsc,
    PhGs,
    PhEscC,
    PhGsV,
    PhSkip
  } phase_e;

  typedef enum logic [2:0] {
    TokChar,
    TokLine,
    TokTab,
    TokCut,
    TokUlOn,
    TokUlOff
  } tok_kind_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] code;
  } tok_t;

  typedef struct packed {
    logic emit;
    tok_t tok;
  } dec_t;

  // Argument count of a sub-command; sel marks a selector byte that follows
  typedef struct packed {
    logic       sel;
    logic [1:0] cnt;
  } args_t;

  function automatic logic [1:0] dle_args(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    case (b) inside
      8'h04, 8'h05: n = 2'd1;
      8'h14:        n = 2'd3;
      default:      n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic args_t esc_args(input logic [7:0] b);
    args_t a;
    a = '0;
    case (b) inside
      8'h0c, 8'h20, 8'h21, 8'h25, 8'h2d, 8'h32, 8'h33, 8'h3d, 8'h3f, 8'h45,
      8'h47, 8'h4a, 8'h4c, 8'h4d, 8'h52, 8'h54, 8'h56, 8'h61, 8'h64, 8'h74,
      8'h7b:        a.cnt = 2'd1;
      8'h24, 8'h5c: a.cnt = 2'd2;
      8'h70:        a.cnt = 2'd3;
      8'h63:        a.sel = 1'b1;
      default:      a = '0;
    endcase
    return a;
  endfunction

  function automatic args_t gs_args(input logic [7:0] b);
    args_t a;
    a = '0;
    case (b) inside
      8'h21, 8'h2f, 8'h3a, 8'h42, 8'h45, 8'h48, 8'h49, 8'h54, 8'h61, 8'h62,
      8'h66, 8'h68, 8'h72, 8'h77:
        a.cnt = 2'd1;
      8'h24, 8'h4c, 8'h50, 8'h57, 8'h5c:
        a.cnt = 2'd2;
      8'h5e:   a.cnt = 2'd3;
      8'h56:   a.sel = 1'b1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[src/ecsf_in_if.sv]
// Input word channel of the ESC/POS filter: one stream byte and its block-end flag.
// No dependencies.
interface ecsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_block;

  modport source (output valid, output data_byte, output last_of_block, input ready);
  modport sink   (input valid, input data_byte, input last_of_block, output ready);
endinterface

[src/ecsf_out_if.sv]
// Output word channel of the ESC/POS filter: one display token.
// No dependencies.
interface ecsf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] char_code;

  modport source (output valid, output token_kind, output char_code, input ready);
  modport sink   (input valid, input token_kind, input char_code, output ready);
endinterface

[src/ecsf_in_stage.sv]
// Input register of the ESC/POS filter.
// Depends on ecsf_in_if.
module ecsf_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  ecsf_in_if.sink         in_i,
  input  logic            adv_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  assign in_i.ready = !valid_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_of_block;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

[src/ecsf_decode.sv]
// Parser state and per-byte decode of the ESC/POS filter.
// Depends on ecsf_pkg.
module ecsf_decode import ecsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       adv_i,
  output dec_t       dec_o
);

  phase_e     phase_q, phase_d;
  logic [1:0] skip_q, skip_d;
  logic       ul_q, ul_d;
  logic       go;
  logic [1:0] go_n;
  args_t      a;

  always_comb begin
    phase_d       = phase_q;
    skip_d        = skip_q;
    ul_d          = ul_q;
    go            = 1'b0;
    go_n          = 2'd0;
    a             = '0;
    dec_o.emit    = 1'b0;
    dec_o.tok.kind = TokChar;
    dec_o.tok.code = 8'd0;

    unique case (phase_q)
      PhIdle: begin
        case (byte_i) inside
          ByteTab: begin
            dec_o.emit     = 1'b1;
            dec_o.tok.kind = TokTab;
          end
          ByteLf: begin
            dec_o.emit     = 1'b1;
            dec_o.tok.kind = TokLine;
          end
          ByteFf, ByteCr, ByteCan, ByteFs: ;
          ByteDle: phase_d = PhDle;
          ByteEsc: phase_d = PhEsc;
          ByteGs:  phase_d = PhGs;
          default: begin
            dec_o.emit     = 1'b1;
            dec_o.tok.code = byte_i;
          end
        endcase
      end
      PhDle: begin
        go   = 1'b1;
        go_n = dle_args(byte_i);
      end
      PhEsc: begin
        a = esc_args(byte_i);
        if (a.sel) begin
          phase_d = PhEscC;
        end else begin
          // underline toggles on the '-' byte whatever its argument
          if (byte_i == ByteUline) begin
            dec_o.emit     = 1'b1;
            dec_o.tok.kind = ul_q ? TokUlOff : TokUlOn;
            ul_d           = !ul_q;
          end
          go   = 1'b1;
          go_n = a.cnt;
        end
      end
      PhGs: begin
        a = gs_args(byte_i);
        if (a.sel) begin
          phase_d = PhGsV;
        end else begin
          go   = 1'b1;
          go_n = a.cnt;
        end
      end
      PhEscC: begin
        go   = 1'b1;
        go_n = (byte_i >= EscCSelLo && byte_i <= EscCSelHi) ? 2'd1 : 2'd0;
      end
      PhGsV: begin
        go = 1'b1;
        if (byte_i == CutFull0 || byte_i == CutPart0 ||
            byte_i == CutFull48 || byte_i == CutPart49) begin
          dec_o.emit     = 1'b1;
          dec_o.tok.kind = TokCut;
        end else if (byte_i == CutFeedFull || byte_i == CutFeedPart) begin
          dec_o.emit     = 1'b1;
          dec_o.tok.kind = TokCut;
          go_n           = 2'd1;
        end
      end
      PhSkip: begin
        if (skip_q <= 2'd1) begin
          go = 1'b1;
        end else begin
          skip_d = skip_q - 2'd1;
        end
      end
      default: go = 1'b1;
    endcase

    if (go) begin
      phase_d = (go_n == 2'd0) ? PhIdle : PhSkip;
      skip_d  = go_n;
    end

    // block end drops any unfinished command
    if (last_i) begin
      phase_d = PhIdle;
      skip_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      skip_q  <= 2'd0;
      ul_q    <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      ul_q    <= ul_d;
    end
  end

endmodule

[src/ecsf_out_stage.sv]
// Result register of the ESC/POS filter.
// Depends on ecsf_pkg and ecsf_out_if.
module ecsf_out_stage import ecsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  tok_t        tok_i,
  output logic        free_o,
  ecsf_out_if.source  out_o
);

  logic valid_q, valid_d;
  tok_t tok_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= tok_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.token_kind = tok_q.kind;
  assign out_o.char_code  = tok_q.code;

endmodule

[src/escpos_command_stream_filter.sv]
// ESC/POS command stream filter: takes one printer byte per word and emits display tokens
// (character, line feed, tab, paper cut, underline on/off), swallowing DLE/ESC/GS commands
// and their argument bytes. The filter takes one byte per cycle while it is not held back; a byte
// is held in the input register, decoded, and its token is loaded into the result register when
// the byte advances. Only a byte that yields a token while the result register is full and
// not being taken holds back the input. The underline flag survives block ends; last_of_block
// returns the parser to idle.
// Depends on ecsf_pkg, ecsf_in_if, ecsf_out_if.
module escpos_command_stream_filter import ecsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ecsf_in_if.sink     in_i,
  ecsf_out_if.source  out_o
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       adv;
  logic       out_free;
  dec_t       dec;

  // advance the held byte unless its token would land on a full result register that is not being taken
  assign adv = s1_valid && (!dec.emit || out_free);

  ecsf_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .byte_o  (s1_byte),
    .last_o  (s1_last)
  );

  ecsf_decode u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (s1_byte),
    .last_i (s1_last),
    .adv_i  (adv),
    .dec_o  (dec)
  );

  ecsf_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv && dec.emit),
    .tok_i  (dec.tok),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

[verif/tb_escpos_command_stream_filter.sv]
`timescale 1ns / 100ps
// Testbench for the ESC/POS command stream filter: drives byte words, predicts the tokens
// in a scoreboard class and checks every token word. Depends on ecsf_pkg, ecsf_in_if,
// ecsf_out_if and escpos_command_stream_filter.
module tb_escpos_command_stream_filter;
  import ecsf_pkg::*;

  localparam int SelFollows   = 4;
  localparam int StreamBytes  = 1150;
  localparam int StallLimit   = 4000;
  localparam int DrainCycles  = 8;

  // Sub-command bytes used by name in the directed part
  localparam logic [7:0] SubDleRt   = 8'h14;
  localparam logic [7:0] SubEscTodo = 8'h2a;
  localparam logic [7:0] SubEscC    = 8'h63;
  localparam logic [7:0] SubEscPuls = 8'h70;
  localparam logic [7:0] SubGsV     = 8'h56;

  logic clk_i;
  logic rst_ni;

  ecsf_in_if  in_bus ();
  ecsf_out_if out_bus ();

  escpos_command_stream_filter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #2 clk_i = ~clk_i;

  // Argument bytes after a prefix and sub-command; SelFollows marks a selector byte
  function automatic int arg_bytes(input phase_e prefix, input logic [7:0] b);
    int n;
    n = 0;
    case (prefix)
      PhDle: begin
        case (b)
          8'h04, 8'h05: n = 1;
          8'h14:        n = 3;
          default:      n = 0;
        endcase
      end
      PhEsc: begin
        case (b)
          8'h0c, 8'h20, 8'h21, 8'h25, 8'h2d, 8'h32, 8'h33, 8'h3d, 8'h3f, 8'h45, 8'h47,
          8'h4a, 8'h4c, 8'h4d, 8'h52, 8'h54, 8'h56, 8'h61, 8'h64, 8'h74, 8'h7b: n = 1;
          8'h24, 8'h5c: n = 2;
          8'h70:        n = 3;
          8'h63:        n = SelFollows;
          default:      n = 0;
        endcase
      end
      PhGs: begin
        case (b)
          8'h21, 8'h2f, 8'h3a, 8'h42, 8'h45, 8'h48, 8'h49, 8'h54, 8'h61, 8'h62, 8'h66,
          8'h68, 8'h72, 8'h77: n = 1;
          8'h24, 8'h4c, 8'h50, 8'h57, 8'h5c: n = 2;
          8'h5e:   n = 3;
          8'h56:   n = SelFollows;
          default: n = 0;
        endcase
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  class token_scoreboard;
    phase_e     phase;
    logic [1:0] skip_left;
    bit         uline_open;
    tok_t       expected_tokens[$];
    int         errors;

    function new();
      phase      = PhIdle;
      skip_left  = 2'd0;
      uline_open = 1'b0;
      errors     = 0;
    endfunction

    function void enter_skip(input int n);
      if (n == 0) begin
        phase     = PhIdle;
        skip_left = 2'd0;
      end else begin
        phase     = PhSkip;
        skip_left = n[1:0];
      end
    endfunction

    function void push_token(input tok_kind_e kind, input logic [7:0] code);
      tok_t t;
      t.kind = kind;
      t.code = code;
      expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    // Advance the parser by one accepted byte word and queue the token it yields
    function void note_byte(input logic [7:0] b, input logic end_of_block);
      int a;
      case (phase)
        PhIdle: begin
          case (b)
            ByteTab: push_token(TokTab, 8'h00);
            ByteLf:  push_token(TokLine, 8'h00);
            ByteFf, ByteCr, ByteCan, ByteFs: ;
            ByteDle: phase = PhDle;
            ByteEsc: phase = PhEsc;
            ByteGs:  phase = PhGs;
            default: push_token(TokChar, b);
          endcase
        end
        PhDle: enter_skip(arg_bytes(PhDle, b));
        PhEsc: begin
          a = arg_bytes(PhEsc, b);
          if (a == SelFollows) begin
            phase = PhEscC;
          end else begin
            if (b == ByteUline) begin
              push_token(uline_open ? TokUlOff : TokUlOn, 8'h00);
              uline_open = !uline_open;
            end
            enter_skip(a);
          end
        end
        PhGs: begin
          a = arg_bytes(PhGs, b);
          if (a == SelFollows) phase = PhGsV;
          else enter_skip(a);
        end
        PhEscC: enter_skip((b >= EscCSelLo && b <= EscCSelHi) ? 1 : 0);
        PhGsV: begin
          if (b == CutFull0 || b == CutPart0 || b == CutFull48 || b == CutPart49) begin
            push_token(TokCut, 8'h00);
            enter_skip(0);
          end else if (b == CutFeedFull || b == CutFeedPart) begin
            push_token(TokCut, 8'h00);
            enter_skip(1);
          end else begin
            enter_skip(0);
          end
        end
        PhSkip: begin
          if (skip_left <= 2'd1) enter_skip(0);
          else skip_left = skip_left - 2'd1;
        end
        default: enter_skip(0);
      endcase
      if (end_of_block) enter_skip(0);
    endfunction

    function void check_token(input logic [2:0] kind, input logic [7:0] code);
      tok_t want;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: token_kind %0d char_code 0x%02h", kind, code);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        if (kind !== want.kind) begin
          $error("token_kind mismatch: expected %0d, actual %0d", want.kind, kind);
          errors++;
        end
        if (code !== want.code) begin
          $error("char_code mismatch: expected 0x%02h, actual 0x%02h", want.code, code);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  token_scoreboard sb;
  int bytes_sent;
  int burst_left;
  int idle_cycles;
  int rx_left;
  int rx_mode;
  logic rx_ready;

  // Receiver: switch between stall patterns in windows of random length
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(16, 200);
      rx_mode = $urandom_range(0, 3);
    end
    rx_left--;
    case (rx_mode)
      0:       rx_ready = 1'b1;
      1:       rx_ready = 1'($urandom_range(0, 1));
      2:       rx_ready = (rx_left % 8) >= 3;
      default: rx_ready = (rx_left % 24) < 4;
    endcase
    out_bus.ready <= rx_ready;
  end

  // Monitor and watchdog, all sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (in_bus.valid && in_bus.ready) sb.note_byte(in_bus.data_byte, in_bus.last_of_block);
      if (out_bus.valid && out_bus.ready) sb.check_token(out_bus.token_kind, out_bus.char_code);
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one byte word; open a new burst after a random gap when the old one is used up
  task automatic send_byte(input logic [7:0] b, input logic end_of_block);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_bus.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= b;
    in_bus.last_of_block <= end_of_block;
    do @(posedge clk_i); while (!in_bus.ready);
    burst_left--;
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_sub(input phase_e prefix);
    logic [7:0] esc_subs[$] = '{8'h0c, 8'h20, 8'h21, 8'h24, 8'h25, 8'h26, 8'h2a, 8'h2d,
                                8'h32, 8'h33, 8'h3d, 8'h3f, 8'h40, 8'h44, 8'h45, 8'h47,
                                8'h4a, 8'h4c, 8'h4d, 8'h52, 8'h54, 8'h56, 8'h57, 8'h5c,
                                8'h61, 8'h63, 8'h64, 8'h70, 8'h74, 8'h7b};
    logic [7:0] gs_subs[$]  = '{8'h21, 8'h24, 8'h28, 8'h2a, 8'h2f, 8'h3a, 8'h42, 8'h43,
                                8'h45, 8'h48, 8'h49, 8'h4c, 8'h50, 8'h54, 8'h56, 8'h57,
                                8'h5c, 8'h5e, 8'h61, 8'h62, 8'h66, 8'h68, 8'h6b, 8'h72,
                                8'h76, 8'h77};
    logic [7:0] dle_subs[$] = '{8'h04, 8'h05, 8'h14};
    if ($urandom_range(0, 9) < 3) return 8'($urandom_range(0, 255));
    case (prefix)
      PhDle:   return dle_subs[$urandom_range(0, dle_subs.size() - 1)];
      PhEsc:   return esc_subs[$urandom_range(0, esc_subs.size() - 1)];
      default: return gs_subs[$urandom_range(0, gs_subs.size() - 1)];
    endcase
  endfunction

  // Build one command or text run, sometimes cut short or ended by a block end, then send it
  task automatic send_sequence();
    logic [7:0] seq[$];
    logic       ends[$];
    logic [7:0] ctl_bytes[$] = '{ByteLf, ByteTab, ByteCr, ByteFf, ByteCan, ByteFs};
    logic [7:0] cut_sels[$]  = '{CutFull0, CutPart0, CutFull48, CutPart49,
                                 CutFeedFull, CutFeedPart};
    logic [7:0] sub;
    logic [7:0] sel;
    phase_e     prefix;
    int         r;
    int         n;
    bit         is_cmd;
    r      = $urandom_range(0, 99);
    is_cmd = 1'b1;
    prefix = PhIdle;
    if (r < 30) begin
      is_cmd = 1'b0;
      repeat ($urandom_range(1, 8))
        seq.insert(seq.size(), ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(8'h20, 8'h7e)));
    end else if (r < 38) begin
      is_cmd = 1'b0;
      seq.insert(seq.size(), ctl_bytes[$urandom_range(0, ctl_bytes.size() - 1)]);
    end else if (r < 48) begin
      prefix = PhDle;
      seq.insert(seq.size(), ByteDle);
    end else if (r < 80) begin
      prefix = PhEsc;
      seq.insert(seq.size(), ByteEsc);
    end else if (r < 95) begin
      prefix = PhGs;
      seq.insert(seq.size(), ByteGs);
    end else begin
      is_cmd = 1'b0;
      repeat ($urandom_range(1, 4)) begin
        seq.insert(seq.size(), 8'($urandom_range(0, 255)));
        ends.insert(ends.size(), $urandom_range(0, 4) == 0);
      end
    end
    if (is_cmd) begin
      if (prefix == PhEsc && r >= 70) sub = ByteUline;
      else if (prefix == PhGs && r >= 88) sub = SubGsV;
      else sub = pick_sub(prefix);
      seq.insert(seq.size(), sub);
      n = arg_bytes(prefix, sub);
      if (n == SelFollows && prefix == PhEsc) begin
        sel = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(EscCSelLo, EscCSelHi));
        seq.insert(seq.size(), sel);
        n = (sel >= EscCSelLo && sel <= EscCSelHi) ? 1 : 0;
      end else if (n == SelFollows) begin
        sel = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : cut_sels[$urandom_range(0, cut_sels.size() - 1)];
        seq.insert(seq.size(), sel);
        n = (sel == CutFeedFull || sel == CutFeedPart) ? 1 : 0;
      end
      repeat (n) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      // Break some commands off early; a one-byte remnant is closed with a block end
      if (seq.size() > 1 && $urandom_range(0, 99) < 8)
        seq = seq[0:$urandom_range(0, seq.size() - 2)];
    end
    if (ends.size() == 0) begin
      foreach (seq[i]) ends.insert(ends.size(), 1'b0);
      if ((is_cmd && seq.size() < 2) || $urandom_range(0, 99) < 6) ends[ends.size() - 1] = 1'b1;
    end
    foreach (seq[i]) send_byte(seq[i], ends[i]);
  endtask

  initial begin
    logic [8:0] directed[] = '{
      {1'b0, 8'h00}, {1'b0, 8'hff}, {1'b0, ByteTab}, {1'b0, ByteLf}, {1'b0, ByteCr},
      {1'b0, ByteFf}, {1'b0, ByteCan}, {1'b0, ByteFs},
      {1'b0, ByteEsc}, {1'b0, ByteUline}, {1'b0, 8'hff},
      {1'b0, ByteGs}, {1'b0, SubGsV}, {1'b0, CutFeedFull}, {1'b0, ByteLf},
      {1'b0, ByteGs}, {1'b0, SubGsV}, {1'b0, 8'h07},
      {1'b0, ByteEsc}, {1'b0, SubEscC}, {1'b0, 8'h34}, {1'b0, ByteLf},
      {1'b0, ByteDle}, {1'b0, SubDleRt}, {1'b0, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h03},
      {1'b0, ByteEsc}, {1'b0, SubEscTodo}, {1'b0, 8'h42},
      {1'b0, ByteEsc}, {1'b1, SubEscPuls},
      {1'b0, ByteEsc}, {1'b0, ByteUline}, {1'b1, 8'h00}
    };
    sb                   = new();
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = 8'h00;
    in_bus.last_of_block = 1'b0;
    out_bus.ready        = 1'b0;
    bytes_sent           = 0;
    burst_left           = 0;
    idle_cycles          = 0;
    rx_left              = 0;
    rx_mode              = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    while (bytes_sent < StreamBytes) send_sequence();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[escpos_command_stream_filter.f]
src/ecsf_pkg.sv
src/ecsf_in_if.sv
src/ecsf_out_if.sv
src/ecsf_in_stage.sv
src/ecsf_decode.sv
src/ecsf_out_stage.sv
src/escpos_command_stream_filter.sv
verif/tb_escpos_command_stream_filter.sv
